@@ sv/wsv_pkg.sv @@
// Package for the WAV stream volume player: beat types, parser phase codes,
// status codes, operation codes and RIFF tags. Depends on nothing.
package wsv_pkg;

  localparam int CFG_W   = 32;
  localparam int VOL_W   = 4;
  localparam int SMP_W   = 16;
  localparam int MAG_W   = SMP_W + VOL_W - 1;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic CFG_VOLUME = 1'b0;
  localparam logic CFG_RATE   = 1'b1;

  localparam logic [VOL_W-1:0] VOLUME_RST = 4'd5;
  localparam logic [31:0]      RATE_RST   = 32'd16000;

  localparam logic [2:0] ST_PARSING  = 3'd0;
  localparam logic [2:0] ST_PLAYING  = 3'd1;
  localparam logic [2:0] ST_FINISHED = 3'd2;
  localparam logic [2:0] ST_HDR_ERR  = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_STOPPED  = 3'd5;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] LEN_BAD  = 32'hffff_ffff;

  typedef enum logic [9:0] {
    PH_IDLE = 10'b00_0000_0001,
    PH_RIFF = 10'b00_0000_0010,
    PH_CHDR = 10'b00_0000_0100,
    PH_FMT  = 10'b00_0000_1000,
    PH_SKIP = 10'b00_0001_0000,
    PH_DATA = 10'b00_0010_0000,
    PH_DONE = 10'b00_0100_0000,
    PH_HERR = 10'b00_1000_0000,
    PH_MISM = 10'b01_0000_0000,
    PH_STOP = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic                    frame_valid;
    logic [2:0]              status;
  } out_beat_t;

  typedef struct packed {
    logic             frame;
    logic [SMP_W-1:0] raw;
    logic [2:0]       status;
  } job_t;

  function automatic logic [2:0] phase_status(input phase_t ph);
    logic [2:0] st;
    case (ph)
      PH_DATA: st = ST_PLAYING;
      PH_DONE: st = ST_FINISHED;
      PH_HERR: st = ST_HDR_ERR;
      PH_MISM: st = ST_MISMATCH;
      PH_STOP, PH_IDLE: st = ST_STOPPED;
      default: st = ST_PARSING;
    endcase
    return st;
  endfunction

endpackage

@@ sv/wsv_front.sv @@
// Front end of the WAV stream volume player: the RIFF/WAVE chunk parser.
// Turns each accepted beat into one job for the scaler. Depends on wsv_pkg.
module wsv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  wsv_pkg::in_beat_t beat,
  input  logic [31:0]       expected_rate,
  output wsv_pkg::job_t     job
);

  wsv_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] fcode_r, fcode_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [7:0]  low_r, low_nxt;

  logic        frame;
  logic [7:0]  b;
  logic        eos;
  logic [3:0]  cnt_inc;
  logic [31:0] id_sh, len_sh, len_pad, fmt_skip, len_dec, rem_dec;
  logic        mism;

  always_comb begin
    b        = beat.data_byte;
    eos      = beat.end_of_stream;
    cnt_inc  = cnt_r + 4'd1;
    id_sh    = {id_r[23:0], b};
    len_sh   = {b, len_r[31:8]};
    len_pad  = len_sh + {31'd0, len_sh[0]};
    fmt_skip = (len_r > 32'd16) ? (len_r - 32'd16 + {31'd0, len_r[0]}) : {31'd0, len_r[0]};
    len_dec  = len_r - 32'd1;
    rem_dec  = rem_r - 32'd1;
    mism     = (fcode_r != 16'd1) || (chans_r != 16'd1) || (bits_r != 16'd16) ||
               (rate_r != expected_rate);

    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    fcode_nxt    = fcode_r;
    chans_nxt    = chans_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    fmt_seen_nxt = fmt_seen_r;
    rem_nxt      = rem_r;
    low_nxt      = low_r;
    frame        = 1'b0;

    if (accept) begin
      case (beat.operation)
        wsv_pkg::OP_START: begin
          phase_nxt    = wsv_pkg::PH_RIFF;
          cnt_nxt      = '0;
          id_nxt       = '0;
          len_nxt      = '0;
          fcode_nxt    = '0;
          chans_nxt    = '0;
          rate_nxt     = '0;
          bits_nxt     = '0;
          fmt_seen_nxt = 1'b0;
          rem_nxt      = '0;
          low_nxt      = '0;
        end
        wsv_pkg::OP_STOP: begin
          if (phase_r inside {wsv_pkg::PH_RIFF, wsv_pkg::PH_CHDR, wsv_pkg::PH_FMT,
                              wsv_pkg::PH_SKIP, wsv_pkg::PH_DATA}) begin
            phase_nxt = wsv_pkg::PH_STOP;
          end
        end
        wsv_pkg::OP_BYTE: begin
          case (phase_r)
            wsv_pkg::PH_RIFF: begin
              id_nxt  = id_sh;
              cnt_nxt = cnt_inc;
              if ((cnt_r == 4'd3 && id_sh != wsv_pkg::TAG_RIFF) ||
                  (cnt_r == 4'd11 && id_sh != wsv_pkg::TAG_WAVE)) begin
                phase_nxt = wsv_pkg::PH_HERR;
              end else if (cnt_r == 4'd11) begin
                cnt_nxt   = '0;
                len_nxt   = '0;
                phase_nxt = wsv_pkg::PH_CHDR;
              end
              if (eos) begin
                phase_nxt = wsv_pkg::PH_HERR;
              end
            end
            wsv_pkg::PH_CHDR: begin
              if (cnt_r < 4'd4) begin
                id_nxt = id_sh;
              end else begin
                len_nxt = len_sh;
              end
              cnt_nxt = cnt_inc;
              if (cnt_r == 4'd7) begin
                cnt_nxt = '0;
                if (len_sh == wsv_pkg::LEN_BAD) begin
                  phase_nxt = wsv_pkg::PH_HERR;
                end else if (id_r == wsv_pkg::TAG_FMT) begin
                  phase_nxt = eos ? wsv_pkg::PH_HERR : wsv_pkg::PH_FMT;
                end else if (id_r == wsv_pkg::TAG_DATA) begin
                  if (!fmt_seen_r) begin
                    phase_nxt = wsv_pkg::PH_HERR;
                  end else if (mism) begin
                    phase_nxt = wsv_pkg::PH_MISM;
                  end else begin
                    rem_nxt   = len_sh;
                    phase_nxt = (len_sh == 32'd0 || eos) ? wsv_pkg::PH_DONE : wsv_pkg::PH_DATA;
                  end
                end else begin
                  len_nxt = len_pad;
                  if (eos) begin
                    phase_nxt = wsv_pkg::PH_HERR;
                  end else begin
                    phase_nxt = (len_pad == 32'd0) ? wsv_pkg::PH_CHDR : wsv_pkg::PH_SKIP;
                  end
                end
              end else if (eos) begin
                phase_nxt = wsv_pkg::PH_HERR;
              end
            end
            wsv_pkg::PH_FMT: begin
              if (cnt_r < 4'd2) begin
                fcode_nxt = {b, fcode_r[15:8]};
              end else if (cnt_r < 4'd4) begin
                chans_nxt = {b, chans_r[15:8]};
              end else if (cnt_r < 4'd8) begin
                rate_nxt = {b, rate_r[31:8]};
              end else if (cnt_r >= 4'd14) begin
                bits_nxt = {b, bits_r[15:8]};
              end
              cnt_nxt = cnt_inc;
              if (cnt_r == 4'd15) begin
                fmt_seen_nxt = 1'b1;
                cnt_nxt      = '0;
                len_nxt      = fmt_skip;
                phase_nxt    = (fmt_skip == 32'd0) ? wsv_pkg::PH_CHDR : wsv_pkg::PH_SKIP;
              end
              if (eos) begin
                phase_nxt = wsv_pkg::PH_HERR;
              end
            end
            wsv_pkg::PH_SKIP: begin
              len_nxt = len_dec;
              if (len_dec == 32'd0) begin
                cnt_nxt   = '0;
                phase_nxt = wsv_pkg::PH_CHDR;
              end
              if (eos) begin
                phase_nxt = wsv_pkg::PH_HERR;
              end
            end
            wsv_pkg::PH_DATA: begin
              if (!cnt_r[0]) begin
                low_nxt = b;
              end else begin
                frame = 1'b1;
              end
              cnt_nxt = cnt_inc;
              rem_nxt = rem_dec;
              if (rem_dec == 32'd0 || eos) begin
                phase_nxt = wsv_pkg::PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    job.frame  = frame;
    job.raw    = {b, low_r};
    job.status = wsv_pkg::phase_status(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsv_pkg::PH_IDLE;
      cnt_r      <= '0;
      id_r       <= '0;
      len_r      <= '0;
      fcode_r    <= '0;
      chans_r    <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      fmt_seen_r <= 1'b0;
      rem_r      <= '0;
      low_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      fcode_r    <= fcode_nxt;
      chans_r    <= chans_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      rem_r      <= rem_nxt;
      low_r      <= low_nxt;
    end
  end

endmodule

@@ sv/wsv_queue.sv @@
// Short job queue between the parser and the scaler of the WAV stream
// volume player. Depends on wsv_pkg.
module wsv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsv_pkg::job_t push_job,
  input  logic          pop,
  output wsv_pkg::job_t head_job,
  output logic          empty,
  output logic          full
);

  wsv_pkg::job_t               mem_r [wsv_pkg::QDEPTH];
  logic [wsv_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [wsv_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [wsv_pkg::QPTR_W:0]    count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (wsv_pkg::QPTR_W+1)'(wsv_pkg::QDEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ sv/wsv_back.sv @@
// Back end of the WAV stream volume player: scales each sample by
// volume / MAX_VOLUME in three stages and holds the output beat. Depends on wsv_pkg.
module wsv_back #(
  parameter int MAX_VOLUME = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [wsv_pkg::VOL_W-1:0]   volume,
  input  logic                        job_valid,
  input  wsv_pkg::job_t               job,
  output logic                        job_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wsv_pkg::out_beat_t          out_data
);

  localparam int PROD_W = wsv_pkg::SMP_W + wsv_pkg::VOL_W + 1;
  localparam int MAG_W  = wsv_pkg::MAG_W;
  localparam int SHIFT  = MAG_W + $clog2(MAX_VOLUME);
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(MAX_VOLUME) - 64'd1) / 64'(MAX_VOLUME);
  localparam logic [MAG_W:0] RECIP_V = RECIP[MAG_W:0];

  logic                     adv;
  logic                     v1_r, v2_r, out_valid_r;
  logic                     frame1_r, frame2_r;
  logic [2:0]               st1_r, st2_r;
  logic signed [PROD_W-1:0] prod1_r, prod_nxt;
  logic [PROD_W-1:0]        prod_abs;
  logic [MAG_W-1:0]         mag;
  logic [2*MAG_W:0]         qprod;
  logic [MAG_W-1:0]         q2_r, q_nxt;
  logic                     neg2_r;
  logic signed [wsv_pkg::SMP_W-1:0] smp;
  wsv_pkg::out_beat_t       out_r, out_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign job_pop   = adv && job_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    prod_nxt = PROD_W'($signed(job.raw)) * PROD_W'($signed({1'b0, volume}));
    prod_abs = prod1_r[PROD_W-1] ? PROD_W'(-prod1_r) : PROD_W'(prod1_r);
    mag      = prod_abs[MAG_W-1:0];
    qprod    = (2*MAG_W+1)'(mag) * (2*MAG_W+1)'(RECIP_V);
    q_nxt    = MAG_W'(qprod >> SHIFT);

    if (!neg2_r) begin
      smp = (q2_r > MAG_W'(32767)) ? 16'sd32767 : $signed(q2_r[15:0]);
    end else begin
      smp = (q2_r > MAG_W'(32768)) ? -16'sd32768 : $signed(16'(-q2_r[15:0]));
    end

    out_nxt.left_sample  = frame2_r ? smp : '0;
    out_nxt.right_sample = frame2_r ? smp : '0;
    out_nxt.frame_valid  = frame2_r;
    out_nxt.status       = st2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r  <= prod_nxt;
      frame1_r <= job.frame;
      st1_r    <= job.status;
      q2_r     <= q_nxt;
      neg2_r   <= prod1_r[PROD_W-1];
      frame2_r <= frame1_r;
      st2_r    <= st1_r;
      if (v2_r) begin
        out_r <= out_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= job_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

endmodule

@@ sv/wav_stream_volume_player.sv @@
// Top level of the WAV stream volume player: configuration registers,
// parser front end, job queue and scaling back end. Depends on wsv_pkg.
//
//   Port group   Direction   Handshake            Beat
//   in_*         input       in_valid/in_ready    one file byte or operation
//   out_*        output      out_valid/out_ready  one status beat, maybe a frame
//   cfg_*        input       cfg_wr_en            volume or expected rate
//
// One beat in per cycle while the queue is not full; each result is queued first.
// The parser updates its state in the cycle of acceptance, and a four-entry
// queue feeds a three-stage scaler (multiply, reciprocal multiply, saturate).
// in_ready drops only when the queue is full; an output stall freezes the scaler.
// Reset is synchronous; the parser comes up idle and reports stopped.
module wav_stream_volume_player #(
  parameter int MAX_VOLUME = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wsv_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output wsv_pkg::out_beat_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [wsv_pkg::CFG_W-1:0] cfg_wdata
);

  logic [wsv_pkg::VOL_W-1:0] volume_r;
  logic [31:0]               rate_r;
  logic                      accept;
  logic                      q_empty, q_full, q_pop;
  wsv_pkg::job_t             front_job, head_job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= wsv_pkg::VOLUME_RST;
      rate_r   <= wsv_pkg::RATE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wsv_pkg::CFG_VOLUME: volume_r <= cfg_wdata[wsv_pkg::VOL_W-1:0];
        wsv_pkg::CFG_RATE:   rate_r   <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  wsv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .beat          (in_data),
    .expected_rate (rate_r),
    .job           (front_job)
  );

  wsv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_job (front_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  wsv_back #(
    .MAX_VOLUME (MAX_VOLUME)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .volume    (volume_r),
    .job_valid (!q_empty),
    .job       (head_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_frame_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_valid |->
      out_data.status == wsv_pkg::ST_PLAYING || out_data.status == wsv_pkg::ST_FINISHED)
    else $error("Frame beat carries a status other than playing or finished.");

  a_silent_nonframe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_valid |->
      out_data.left_sample == '0 && out_data.right_sample == '0)
    else $error("Beat without a frame carries a nonzero sample.");

  a_mono_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.left_sample == out_data.right_sample)
    else $error("Left and right samples differ.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output beat offered right after reset.");

endmodule
